### hdl/segdrv_pkg.sv
// Shared types, constants and segment tables for the segment display driver.
// No dependencies; used by segdrv_ctrl, segdrv_enc and the top level.
`timescale 1ns / 1ps

package segdrv_pkg;

    typedef logic [15:0] t_word;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_TICK_THRESHOLD   = 2'd0,
        REG_BLINK_PERIOD     = 2'd1,
        REG_BLINK_OFF_FRAMES = 2'd2
    } t_reg_index;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 10;

    localparam logic [6:0] TICK_THRESHOLD_RST   = 7'd10;
    localparam logic [9:0] BLINK_PERIOD_RST     = 10'd500;
    localparam logic [9:0] BLINK_OFF_FRAMES_RST = 10'd100;

    localparam logic [15:0] VALUE_LIMIT = 16'd3000;

    // Frame handed from the control stage to the encoder
    typedef struct packed {
        logic [15:0] value;
        logic        dots;
        logic        blank;
        logic        phase;
    } t_frame;

    localparam t_word SEG_ONES [0:1][0:9] = '{
        '{16'h0039, 16'h0031, 16'h0029, 16'h0039, 16'h0031,
          16'h0019, 16'h0019, 16'h0039, 16'h0039, 16'h0039},
        '{16'h005A, 16'h0000, 16'h0072, 16'h0032, 16'h002A,
          16'h003A, 16'h007A, 16'h0000, 16'h007A, 16'h003A}
    };

    localparam t_word SEG_TENS [0:1][0:9] = '{
        '{16'h02C1, 16'h0000, 16'h01C1, 16'h0181, 16'h0301,
          16'h0381, 16'h03C1, 16'h0000, 16'h03C1, 16'h0381},
        '{16'h0382, 16'h0182, 16'h0302, 16'h0382, 16'h0182,
          16'h0282, 16'h0282, 16'h0382, 16'h0382, 16'h0382}
    };

    localparam t_word SEG_HUNDREDS [0:1][0:9] = '{
        '{16'h1C01, 16'h1801, 16'h1401, 16'h1C01, 16'h1801,
          16'h0C01, 16'h0C01, 16'h1C01, 16'h1C01, 16'h1C01},
        '{16'h2C02, 16'h0000, 16'h3802, 16'h1802, 16'h1402,
          16'h1C02, 16'h3C02, 16'h0000, 16'h3C02, 16'h1C02}
    };

    localparam t_word SEG_THOUSANDS [0:1][0:2] = '{
        '{16'h0000, 16'h6001, 16'hC001},
        '{16'h0000, 16'h0000, 16'h8002}
    };

    localparam t_word SEG_OVERLOAD [0:1] = '{16'h02C1, 16'h03DA};
    localparam t_word SEG_DOTS     [0:1] = '{16'h0000, 16'h0006};

endpackage

### hdl/segdrv_ctrl.sv
// Tick divider, blink frame counter, backplane phase and config registers.
// Registers each framing tick into a frame item for the encoder. Uses segdrv_pkg.
`timescale 1ns / 1ps

module segdrv_ctrl import segdrv_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [15:0]            i_display_value,
    input  logic                   i_blink_on,
    input  logic                   i_dots_on,
    output logic                   o_frame_valid,
    input  logic                   i_frame_ready,
    output t_frame                 o_frame
);

    logic [6:0] r_tick_threshold;
    logic [9:0] r_blink_period;
    logic [9:0] r_blink_off_frames;

    logic [7:0] r_tick_count, n_tick_count;
    logic [9:0] r_frame_count, n_frame_count;
    logic       r_phase, n_phase;
    logic       r_valid, n_valid;
    t_frame     r_frame;

    logic        accept;
    logic        frame_due;
    logic [10:0] fc_inc;

    assign o_ready       = !r_valid || i_frame_ready;
    assign accept        = i_valid && o_ready;
    assign frame_due     = r_tick_count > {1'b0, r_tick_threshold};
    assign fc_inc        = {1'b0, r_frame_count} + 11'd1;
    assign o_frame_valid = r_valid;
    assign o_frame       = r_frame;

    always_comb begin
        n_tick_count  = r_tick_count;
        n_frame_count = r_frame_count;
        n_phase       = r_phase;
        n_valid       = r_valid;
        if (r_valid && i_frame_ready) begin
            n_valid = 1'b0;
        end
        if (accept) begin
            n_valid = frame_due;
            if (frame_due) begin
                // period of zero behaves as one: count stays at zero
                n_frame_count = (fc_inc >= {1'b0, r_blink_period}) ? 10'd0 : fc_inc[9:0];
                n_phase       = !r_phase;
                n_tick_count  = 8'd1;
            end else begin
                n_tick_count  = r_tick_count + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_count  <= '0;
            r_frame_count <= '0;
            r_phase       <= 1'b0;
            r_valid       <= 1'b0;
        end else begin
            r_tick_count  <= n_tick_count;
            r_frame_count <= n_frame_count;
            r_phase       <= n_phase;
            r_valid       <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && frame_due) begin
            r_frame.value <= i_display_value;
            r_frame.dots  <= i_dots_on;
            r_frame.blank <= i_blink_on && (r_frame_count < r_blink_off_frames);
            r_frame.phase <= r_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tick_threshold   <= TICK_THRESHOLD_RST;
            r_blink_period     <= BLINK_PERIOD_RST;
            r_blink_off_frames <= BLINK_OFF_FRAMES_RST;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_TICK_THRESHOLD:   r_tick_threshold   <= i_cfg_data[6:0];
                REG_BLINK_PERIOD:     r_blink_period     <= i_cfg_data;
                REG_BLINK_OFF_FRAMES: r_blink_off_frames <= i_cfg_data;
                default: ;
            endcase
        end
    end

endmodule

### hdl/segdrv_enc.sv
// Segment encoder: decimal digit split, table lookup and result register.
// Depends on segdrv_pkg for the frame type and segment tables.
`timescale 1ns / 1ps

module segdrv_enc import segdrv_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_frame_valid,
    output logic        o_frame_ready,
    input  t_frame      i_frame,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [15:0] o_segment_word,
    output logic        o_backplane_phase
);

    logic        r_valid, n_valid;
    logic [15:0] r_word;
    logic        r_phase;

    logic        take;
    logic        overload;
    logic [11:0] v12;
    logic [1:0]  thou;
    logic [9:0]  rem1;
    logic [3:0]  hund;
    logic [6:0]  rem2;
    logic [3:0]  tens;
    logic [3:0]  ones;
    t_word       word;

    assign o_frame_ready = !r_valid || i_ready;
    assign take          = i_frame_valid && o_frame_ready;

    always_comb begin
        overload = i_frame.value >= VALUE_LIMIT;
        v12      = i_frame.value[11:0];

        if (v12 >= 12'd2000) begin
            thou = 2'd2;
            rem1 = 10'(v12 - 12'd2000);
        end else if (v12 >= 12'd1000) begin
            thou = 2'd1;
            rem1 = 10'(v12 - 12'd1000);
        end else begin
            thou = 2'd0;
            rem1 = v12[9:0];
        end

        // parallel compares against the multiples; the highest passing one wins
        hund = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (rem1 >= 10'(k * 100)) hund = 4'(k);
        end
        rem2 = 7'(rem1 - 10'(hund) * 10'd100);

        tens = 4'd0;
        for (int k = 1; k < 10; k++) begin
            if (rem2 >= 7'(k * 10)) tens = 4'(k);
        end
        ones = 4'(rem2 - 7'(tens) * 7'd10);

        if (i_frame.blank) begin
            word = '0;
        end else if (overload) begin
            word = SEG_OVERLOAD[i_frame.phase];
        end else begin
            word = SEG_THOUSANDS[i_frame.phase][thou]
                 | SEG_HUNDREDS[i_frame.phase][hund]
                 | SEG_TENS[i_frame.phase][tens]
                 | SEG_ONES[i_frame.phase][ones]
                 | (i_frame.dots ? SEG_DOTS[i_frame.phase] : 16'h0000);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (r_valid && i_ready) begin
            n_valid = 1'b0;
        end
        if (take) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_word  <= word;
            r_phase <= i_frame.phase;
        end
    end

    assign o_valid           = r_valid;
    assign o_segment_word    = r_word;
    assign o_backplane_phase = r_phase;

endmodule

### hdl/multiplexed_segment_display_driver_core.sv
// Segment display driver top level: one timer tick item accepted per cycle unless stalled.
// A framing tick gives its segment word through the frame register in segdrv_ctrl
// and then the result register in segdrv_enc; other ticks give none. The
// two-register pipeline moves one item per cycle unless i_ready holds it back.
// Synchronous active-low reset clears counters, phase and valid flags and
// restores the configuration defaults. Depends on segdrv_pkg, segdrv_ctrl, segdrv_enc.
`timescale 1ns / 1ps

module multiplexed_segment_display_driver_core import segdrv_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_valid,
    output logic                   o_cfg_ready,
    input  logic [CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                   i_valid,
    output logic                   o_ready,
    input  logic [15:0]            i_display_value,
    input  logic                   i_blink_on,
    input  logic                   i_dots_on,
    output logic                   o_valid,
    input  logic                   i_ready,
    output logic [15:0]            o_segment_word,
    output logic                   o_backplane_phase
);

    logic   frame_valid;
    logic   frame_ready;
    t_frame frame;

    // registers are always writable
    assign o_cfg_ready = 1'b1;

    segdrv_ctrl u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_display_value (i_display_value),
        .i_blink_on      (i_blink_on),
        .i_dots_on       (i_dots_on),
        .o_frame_valid   (frame_valid),
        .i_frame_ready   (frame_ready),
        .o_frame         (frame)
    );

    segdrv_enc u_enc (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_frame_valid     (frame_valid),
        .o_frame_ready     (frame_ready),
        .i_frame           (frame),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_segment_word    (o_segment_word),
        .o_backplane_phase (o_backplane_phase)
    );

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for multiplexed_segment_display_driver_core: a directed table,
// then random phases under changing settings, checked by a local frame predictor or typed rows.
// Depends on segdrv_pkg and the core RTL.

module testbench;
    import segdrv_pkg::*;

    localparam int HOLD_CYCLES    = 250;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_ITEMS   = 1400;
    localparam int MIN_FRAMES     = 48;
    localparam int DRAIN_CYCLES   = 4;
    localparam int TAIL_CYCLES    = 8;
    localparam logic [15:0] OL_FROM = 16'd3000;

    // Segment patterns per backplane phase
    localparam t_word ONES_PAT [0:1][0:9] = '{
        '{16'h0039, 16'h0031, 16'h0029, 16'h0039, 16'h0031,
          16'h0019, 16'h0019, 16'h0039, 16'h0039, 16'h0039},
        '{16'h005A, 16'h0000, 16'h0072, 16'h0032, 16'h002A,
          16'h003A, 16'h007A, 16'h0000, 16'h007A, 16'h003A}
    };
    localparam t_word TENS_PAT [0:1][0:9] = '{
        '{16'h02C1, 16'h0000, 16'h01C1, 16'h0181, 16'h0301,
          16'h0381, 16'h03C1, 16'h0000, 16'h03C1, 16'h0381},
        '{16'h0382, 16'h0182, 16'h0302, 16'h0382, 16'h0182,
          16'h0282, 16'h0282, 16'h0382, 16'h0382, 16'h0382}
    };
    localparam t_word HUNDREDS_PAT [0:1][0:9] = '{
        '{16'h1C01, 16'h1801, 16'h1401, 16'h1C01, 16'h1801,
          16'h0C01, 16'h0C01, 16'h1C01, 16'h1C01, 16'h1C01},
        '{16'h2C02, 16'h0000, 16'h3802, 16'h1802, 16'h1402,
          16'h1C02, 16'h3C02, 16'h0000, 16'h3C02, 16'h1C02}
    };
    localparam t_word THOUSANDS_PAT [0:1][0:2] = '{
        '{16'h0000, 16'h6001, 16'hC001},
        '{16'h0000, 16'h0000, 16'h8002}
    };
    localparam t_word OL_PAT   [0:1] = '{16'h02C1, 16'h03DA};
    localparam t_word DOTS_PAT [0:1] = '{16'h0000, 16'h0006};

    typedef struct packed {
        t_word word;
        logic  ph;
    } t_seg_frame;

    typedef enum bit {ROW_TICK, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        int          reps;
        t_reg_index  idx;
        logic [9:0]  data;
        logic [15:0] value;
        logic        blink;
        logic        dots;
        bit          typed;
        t_seg_frame  fr;
    } t_dir_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_valid;
    logic                   o_cfg_ready;
    logic [CFG_INDEX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0]  i_cfg_data;
    logic                   i_valid;
    logic                   o_ready;
    logic [15:0]            i_display_value;
    logic                   i_blink_on;
    logic                   i_dots_on;
    logic                   o_valid;
    logic                   i_ready;
    logic [15:0]            o_segment_word;
    logic                   o_backplane_phase;

    // Predictor state and its copy of the registers
    logic [6:0] div_threshold;
    logic [9:0] blink_len;
    logic [9:0] blank_len;
    logic [7:0] tick_cnt;
    logic [9:0] frame_cnt;
    logic       bp_phase;

    t_seg_frame frames_due[$];
    int         mismatches = 0;
    int         frames_seen = 0;
    bit         src_gaps_on = 1'b1;
    bit         sink_stalls_on = 1'b1;
    bit         hold_wanted = 1'b0;
    bit         hold_done = 1'b0;

    multiplexed_segment_display_driver_core uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_ready           (o_ready),
        .i_display_value   (i_display_value),
        .i_blink_on        (i_blink_on),
        .i_dots_on         (i_dots_on),
        .o_valid           (o_valid),
        .i_ready           (i_ready),
        .o_segment_word    (o_segment_word),
        .o_backplane_phase (o_backplane_phase)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic t_word segment_pattern(input logic [15:0] v, input logic dots,
                                              input logic ph);
        t_word w;
        int    n;
        if (v >= OL_FROM)
            return OL_PAT[ph];
        n = v;
        w = THOUSANDS_PAT[ph][(n / 1000) % 3] | HUNDREDS_PAT[ph][(n % 1000) / 100]
            | TENS_PAT[ph][(n % 100) / 10] | ONES_PAT[ph][n % 10];
        if (dots)
            w = w | DOTS_PAT[ph];
        return w;
    endfunction

    // One timer tick through the divider; fired is set when a frame leaves
    task automatic advance_tick(input logic [15:0] v, input logic blink, input logic dots,
                                output bit fired, output t_seg_frame fr);
        int nxt;
        fired = 1'b0;
        fr = '0;
        if (tick_cnt > {1'b0, div_threshold}) begin
            fired = 1'b1;
            fr.ph = bp_phase;
            fr.word = (blink && frame_cnt < blank_len) ? t_word'(0)
                                                        : segment_pattern(v, dots, bp_phase);
            nxt = int'(frame_cnt) + 1;
            frame_cnt = (nxt >= int'(blink_len)) ? 10'd0 : nxt[9:0];
            bp_phase = ~bp_phase;
            tick_cnt = 8'd0;
        end
        tick_cnt = tick_cnt + 8'd1;
    endtask

    // Mostly short gaps, now and then a long one
    function automatic int idle_span(input bit on);
        int r;
        if (!on)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [15:0] pick_value();
        logic [15:0] corners [0:7] = '{16'd0, 16'd999, 16'd1000, 16'd1999,
                                       16'd2000, 16'd2999, 16'd3000, 16'hFFFF};
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: return 16'($urandom_range(0, 2999));
            6:                return 16'($urandom_range(3000, 65535));
            7:                return corners[$urandom_range(0, 7)];
            default:          return 16'($urandom());
        endcase
    endfunction

    function automatic t_dir_row tick_row(input int reps, input logic [15:0] v,
                                          input logic bl, input logic dt);
        t_dir_row r;
        r.kind = ROW_TICK;
        r.reps = reps;
        r.idx = REG_TICK_THRESHOLD;
        r.data = '0;
        r.value = v;
        r.blink = bl;
        r.dots = dt;
        r.typed = 1'b0;
        r.fr = '0;
        return r;
    endfunction

    function automatic t_dir_row frame_row(input logic [15:0] v, input logic bl,
                                           input logic dt, input t_word w, input logic ph);
        t_dir_row r;
        r = tick_row(1, v, bl, dt);
        r.typed = 1'b1;
        r.fr.word = w;
        r.fr.ph = ph;
        return r;
    endfunction

    function automatic t_dir_row reg_row(input t_reg_index idx, input logic [9:0] data);
        t_dir_row r;
        r = tick_row(0, '0, 1'b0, 1'b0);
        r.kind = ROW_REG;
        r.idx = idx;
        r.data = data;
        return r;
    endfunction

    task automatic send_tick(input logic [15:0] v, input logic bl, input logic dt,
                             input bit typed, input t_seg_frame typed_fr);
        int         gap;
        bit         fired;
        t_seg_frame fr;
        gap = idle_span(src_gaps_on);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_display_value <= v;
        i_blink_on <= bl;
        i_dots_on <= dt;
        do @(posedge i_clk); while (o_ready !== 1'b1);
        advance_tick(v, bl, dt, fired, fr);
        if (typed)
            frames_due.push_back(typed_fr);
        else if (fired)
            frames_due.push_back(fr);
    endtask

    // Block must be idle before a register write; a tick with no frame may still be in flight
    task automatic quiesce();
        i_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic cfg_write(input t_reg_index idx, input logic [9:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        case (idx)
            REG_TICK_THRESHOLD:   div_threshold = data[6:0];
            REG_BLINK_PERIOD:     blink_len = data;
            REG_BLINK_OFF_FRAMES: blank_len = data;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Stimulus
    initial begin
        t_dir_row    rows[$];
        int          phase_no;
        int          random_items;
        int          n_items;
        logic [6:0]  thr;
        logic [9:0]  per;
        logic [9:0]  off;
        logic [2:0]  junk;
        i_rst_n <= 1'b0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data <= '0;
        i_valid <= 1'b0;
        i_display_value <= '0;
        i_blink_on <= 1'b0;
        i_dots_on <= 1'b0;
        div_threshold = 7'd10;
        blink_len = 10'd500;
        blank_len = 10'd100;
        tick_cnt = '0;
        frame_cnt = '0;
        bp_phase = 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings: first frame on the twelfth tick, blanked at blink start
        rows.push_back(tick_row(11, 16'hFFFF, 1'b1, 1'b1));
        rows.push_back(frame_row(16'd0, 1'b1, 1'b0, 16'h0000, 1'b0));
        // Upper data bits are dropped for the threshold: every tick frames
        rows.push_back(reg_row(REG_TICK_THRESHOLD, 10'h380));
        rows.push_back(tick_row(1, 16'd0, 1'b0, 1'b1));
        rows.push_back(frame_row(16'd3000, 1'b0, 1'b1, 16'h02C1, 1'b0));
        rows.push_back(frame_row(16'hFFFF, 1'b0, 1'b0, 16'h03DA, 1'b1));
        rows.push_back(tick_row(1, 16'd2999, 1'b0, 1'b1));
        rows.push_back(tick_row(1, 16'd1234, 1'b0, 1'b0));
        // Period dropped below the frame count: wraps on the next frame
        rows.push_back(reg_row(REG_BLINK_PERIOD, 10'd3));
        rows.push_back(reg_row(REG_BLINK_OFF_FRAMES, 10'd1));
        rows.push_back(tick_row(1, 16'd2468, 1'b1, 1'b0));
        rows.push_back(frame_row(16'd1357, 1'b1, 1'b0, 16'h0000, 1'b1));
        // Zero period behaves as one
        rows.push_back(reg_row(REG_BLINK_PERIOD, 10'd0));
        rows.push_back(tick_row(1, 16'd888, 1'b1, 1'b1));
        rows.push_back(frame_row(16'd100, 1'b1, 1'b1, 16'h0000, 1'b1));
        rows.push_back(reg_row(REG_BLINK_OFF_FRAMES, 10'd0));
        rows.push_back(tick_row(1, 16'd70, 1'b1, 1'b0));
        rows.push_back(reg_row(REG_TICK_THRESHOLD, 10'd127));
        rows.push_back(reg_row(REG_BLINK_PERIOD, 10'd1023));
        rows.push_back(reg_row(REG_BLINK_OFF_FRAMES, 10'd1023));
        rows.push_back(tick_row(3, 16'd3, 1'b0, 1'b0));
        // Threshold lowered under the running count: next tick frames
        rows.push_back(reg_row(REG_TICK_THRESHOLD, 10'd2));
        rows.push_back(frame_row(16'd4321, 1'b1, 1'b0, 16'h0000, 1'b1));

        foreach (rows[r]) begin
            if (rows[r].kind == ROW_REG) begin
                quiesce();
                cfg_write(rows[r].idx, rows[r].data);
            end else begin
                for (int k = 0; k < rows[r].reps; k++)
                    send_tick(rows[r].value, rows[r].blink, rows[r].dots,
                              rows[r].typed, rows[r].fr);
            end
        end

        phase_no = 0;
        random_items = 0;
        while ((random_items < RANDOM_ITEMS || frames_seen < MIN_FRAMES) && phase_no < 60) begin
            quiesce();
            if (phase_no == 0)
                thr = 7'd0;
            else case ($urandom_range(0, 7))
                0, 1:    thr = 7'd0;
                2:       thr = 7'd127;
                default: thr = 7'($urandom_range(1, 12));
            endcase
            case ($urandom_range(0, 5))
                0:       per = 10'd0;
                1:       per = 10'd1023;
                default: per = 10'($urandom_range(1, 24));
            endcase
            case ($urandom_range(0, 4))
                0:       off = 10'd0;
                1:       off = 10'd1023;
                default: off = 10'($urandom_range(0, int'(per) + 3));
            endcase
            junk = 3'($urandom_range(0, 7));
            cfg_write(REG_TICK_THRESHOLD, {junk, thr});
            cfg_write(REG_BLINK_PERIOD, per);
            cfg_write(REG_BLINK_OFF_FRAMES, off);
            // First phase: sender flat out while the receiver holds off once
            src_gaps_on = (phase_no != 0) && ($urandom_range(0, 3) != 0);
            sink_stalls_on = ($urandom_range(0, 3) != 0);
            hold_wanted = (phase_no == 0);
            n_items = $urandom_range(60, 130);
            for (int k = 0; k < n_items; k++) begin
                send_tick(pick_value(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                          1'b0, '0);
                random_items++;
            end
            phase_no++;
        end

        i_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("** multiplexed_segment_display_driver_core: PASSED **");
        else
            $display("** multiplexed_segment_display_driver_core: FAILED **");
        $finish;
    end

    // Result side: check accepted frames, drive ready with random stalls
    initial begin
        int         stall_left;
        int         n;
        t_seg_frame want;
        stall_left = 0;
        i_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1) begin
                if (i_ready && o_valid === 1'b1) begin
                    if (frames_due.size() == 0) begin
                        mismatches++;
                        $display("%0t: unexpected frame, expected none, got word %h phase %b",
                                 $time, o_segment_word, o_backplane_phase);
                    end else begin
                        want = frames_due.pop_front();
                        frames_seen++;
                        if (o_segment_word !== want.word) begin
                            mismatches++;
                            $display("%0t: segment_word expected %h got %h",
                                     $time, want.word, o_segment_word);
                        end
                        if (o_backplane_phase !== want.ph) begin
                            mismatches++;
                            $display("%0t: backplane_phase expected %b got %b",
                                     $time, want.ph, o_backplane_phase);
                        end
                    end
                end
                if (stall_left > 0) begin
                    stall_left--;
                    i_ready <= 1'b0;
                end else if (hold_wanted && !hold_done) begin
                    hold_done = 1'b1;
                    stall_left = HOLD_CYCLES - 1;
                    i_ready <= 1'b0;
                end else begin
                    n = idle_span(sink_stalls_on);
                    if (n > 0) begin
                        stall_left = n - 1;
                        i_ready <= 1'b0;
                    end else begin
                        i_ready <= 1'b1;
                    end
                end
            end
        end
    end

    // Watchdog: too long with no item moving on any channel
    initial begin
        int quiet;
        quiet = 0;
        while (quiet < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && o_ready === 1'b1) || (i_cfg_valid && o_cfg_ready === 1'b1)
                || (i_ready && o_valid === 1'b1))
                quiet = 0;
            else
                quiet++;
        end
        $display("** multiplexed_segment_display_driver_core: FAILED **");
        $finish;
    end

endmodule
